// File: src/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

	// Stack and number format.
	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int OUT_DEPTH_W = 5;
	localparam int STATUS_W    = 3;
	localparam int OPS_W       = 16;
	localparam int OP_W        = 2;

	// Intermediate result is wide enough for a shifted product or a quotient.
	localparam int QUOT_W    = DATA_W + FRAC_W;
	localparam int WIDE_W    = QUOT_W + 2;
	localparam int DIV_RADIX = 2;
	localparam int DIV_STEPS = QUOT_W / DIV_RADIX;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FEW     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;

	// Operator codes and item kinds.
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;
	localparam logic KIND_OPER = 1'b1;

	// Microprogram step addresses.
	localparam int UPC_W = 5;
	localparam logic [UPC_W-1:0] S_OUT     = 5'd0;
	localparam logic [UPC_W-1:0] S_WAIT    = 5'd1;
	localparam logic [UPC_W-1:0] S_KIND    = 5'd2;
	localparam logic [UPC_W-1:0] S_CHKFULL = 5'd3;
	localparam logic [UPC_W-1:0] S_PUSH    = 5'd4;
	localparam logic [UPC_W-1:0] S_FULL    = 5'd5;
	localparam logic [UPC_W-1:0] S_RDB     = 5'd6;
	localparam logic [UPC_W-1:0] S_RDA     = 5'd7;
	localparam logic [UPC_W-1:0] S_LDA     = 5'd8;
	localparam logic [UPC_W-1:0] S_CHKMUL  = 5'd9;
	localparam logic [UPC_W-1:0] S_ADDSUB  = 5'd10;
	localparam logic [UPC_W-1:0] S_MUL     = 5'd11;
	localparam logic [UPC_W-1:0] S_MULSH   = 5'd12;
	localparam logic [UPC_W-1:0] S_DIVCHK  = 5'd13;
	localparam logic [UPC_W-1:0] S_DIVINIT = 5'd14;
	localparam logic [UPC_W-1:0] S_DIVLOOP = 5'd15;
	localparam logic [UPC_W-1:0] S_DIVSIGN = 5'd16;
	localparam logic [UPC_W-1:0] S_COMMIT  = 5'd17;
	localparam logic [UPC_W-1:0] S_DZ      = 5'd18;
	localparam logic [UPC_W-1:0] S_FEW     = 5'd19;

	// Jump conditions; a step falls through to the next address when false.
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NEVER   = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS  = 4'd1;
	localparam logic [COND_W-1:0] C_NOFIRE  = 4'd2;
	localparam logic [COND_W-1:0] C_KIND    = 4'd3;
	localparam logic [COND_W-1:0] C_FULL    = 4'd4;
	localparam logic [COND_W-1:0] C_FEW     = 4'd5;
	localparam logic [COND_W-1:0] C_DIV     = 4'd6;
	localparam logic [COND_W-1:0] C_MUL     = 4'd7;
	localparam logic [COND_W-1:0] C_BZERO   = 4'd8;
	localparam logic [COND_W-1:0] C_DIVMORE = 4'd9;
	localparam logic [COND_W-1:0] C_OUTBUSY = 4'd10;

	// Sources for the wide result register.
	localparam logic [1:0] W_NONE   = 2'd0;
	localparam logic [1:0] W_ADDSUB = 2'd1;
	localparam logic [1:0] W_MUL    = 2'd2;
	localparam logic [1:0] W_DIV    = 2'd3;

	typedef struct packed {
		logic [COND_W-1:0]   cond;
		logic [UPC_W-1:0]    target;
		logic                in_rdy;
		logic                rd_sec;
		logic                ld_b;
		logic                ld_a;
		logic [1:0]          wide_sel;
		logic                mul_go;
		logic                div_start;
		logic                div_step;
		logic                push;
		logic                commit;
		logic                st_set;
		logic [STATUS_W-1:0] st_code;
		logic                emit;
	} uword_t;

	typedef struct packed {
		logic kind;
		logic full;
		logic few;
		logic is_div;
		logic is_mul;
		logic b_zero;
		logic div_more;
	} dp_flags_t;

	// The microprogram.
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] pc);
		uword_t w;
		w = '0;
		case (pc)
			S_OUT: begin
				w.emit = 1'b1;
				w.cond = C_OUTBUSY;
				w.target = S_OUT;
			end
			S_WAIT: begin
				w.in_rdy = 1'b1;
				w.cond = C_NOFIRE;
				w.target = S_WAIT;
			end
			S_KIND: begin
				w.cond = C_KIND;
				w.target = S_RDB;
			end
			S_CHKFULL: begin
				w.cond = C_FULL;
				w.target = S_FULL;
			end
			S_PUSH: begin
				w.push = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_FULL: begin
				w.st_set = 1'b1;
				w.st_code = ST_FULL;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_RDB: begin
				w.cond = C_FEW;
				w.target = S_FEW;
			end
			S_RDA: begin
				w.ld_b = 1'b1;
				w.rd_sec = 1'b1;
			end
			S_LDA: begin
				w.ld_a = 1'b1;
				w.cond = C_DIV;
				w.target = S_DIVCHK;
			end
			S_CHKMUL: begin
				w.cond = C_MUL;
				w.target = S_MUL;
			end
			S_ADDSUB: begin
				w.wide_sel = W_ADDSUB;
				w.cond = C_ALWAYS;
				w.target = S_COMMIT;
			end
			S_MUL: begin
				w.mul_go = 1'b1;
			end
			S_MULSH: begin
				w.wide_sel = W_MUL;
				w.cond = C_ALWAYS;
				w.target = S_COMMIT;
			end
			S_DIVCHK: begin
				w.cond = C_BZERO;
				w.target = S_DZ;
			end
			S_DIVINIT: begin
				w.div_start = 1'b1;
			end
			S_DIVLOOP: begin
				w.div_step = 1'b1;
				w.cond = C_DIVMORE;
				w.target = S_DIVLOOP;
			end
			S_DIVSIGN: begin
				w.wide_sel = W_DIV;
			end
			S_COMMIT: begin
				w.commit = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_DZ: begin
				w.st_set = 1'b1;
				w.st_code = ST_DIVZERO;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_FEW: begin
				w.st_set = 1'b1;
				w.st_code = ST_FEW;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: src/rpn_stack_calculator.sv
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid/in_ready    kind, value, op
// output   out_valid/out_ready  status, top_value, depth, ops_done
//
// One item at a time. Push, stack full, too few operands, add/subtract,
// multiply, divide by zero and divide each end in a valid result beat; divide
// runs the two-bits-per-step divider.
// The next input beat is taken in the cycle after the result is registered,
// even while that result still waits for out_ready.
// Reset clears depth, operation count and sequencer; stack contents are not cleared.
// A stalled output holds the sequencer at its emit step until the beat is taken.

module rpn_stack_calculator
	import rsc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire logic [DATA_W-1:0]   value,
	input  wire logic [OP_W-1:0]     op,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [STATUS_W-1:0] status,
	output logic      [DATA_W-1:0]   top_value,
	output logic      [OUT_DEPTH_W-1:0] depth,
	output logic      [OPS_W-1:0]    ops_done
);

	uword_t                  uw;
	dp_flags_t               flags;
	logic                    fire;
	logic                    out_busy;
	logic [STATUS_W-1:0]     dp_status;
	logic [DATA_W-1:0]       dp_top;
	logic [DEPTH_W-1:0]      dp_depth;
	logic [OPS_W-1:0]        dp_ops;
	logic [OUT_DEPTH_W+DEPTH_W-1:0] depth_ext;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DATA_W-1:0]       top_q;
	logic [OUT_DEPTH_W-1:0]  depth_q;
	logic [OPS_W-1:0]        ops_q;

	assign in_ready = uw.in_rdy;
	assign fire     = in_valid & in_ready;
	assign out_busy = out_valid_q & ~out_ready;

	rsc_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.out_busy (out_busy),
		.flags    (flags),
		.uw       (uw)
	);

	rsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.kind      (kind),
		.value     (value),
		.op        (op),
		.uw        (uw),
		.flags     (flags),
		.status    (dp_status),
		.top_value (dp_top),
		.depth     (dp_depth),
		.ops_done  (dp_ops)
	);

	// The reported depth is the full stack count; OUT_DEPTH_W matches its width.
	assign depth_ext = {{OUT_DEPTH_W{1'b0}}, dp_depth};

	// Output register: loaded at the emit step once the previous beat is gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && !out_busy) begin
			status_q <= dp_status;
			top_q    <= dp_top;
			depth_q  <= depth_ext[OUT_DEPTH_W-1:0];
			ops_q    <= dp_ops;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_q;
	assign depth     = depth_q;
	assign ops_done  = ops_q;

endmodule

`default_nettype wire

// File: src/rsc_stack.sv
`default_nettype none

module rsc_stack
	import rsc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/rsc_div.sv
`default_nettype none

module rsc_div
	import rsc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [DATA_W-1:0] dividend_mag,
	input  wire logic [DATA_W-1:0] divisor_mag,
	output logic      [QUOT_W-1:0] quot,
	output logic                   more
);

	logic [QUOT_W-1:0]    q_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    d_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [QUOT_W-1:0]    q_nxt;
	logic [DATA_W:0]      r_nxt;

	// Restoring division, DIV_RADIX quotient bits per step.
	always_comb begin
		q_nxt = q_q;
		r_nxt = {1'b0, rem_q};
		for (int i = 0; i < DIV_RADIX; i++) begin
			r_nxt = {r_nxt[DATA_W-1:0], q_nxt[QUOT_W-1]};
			q_nxt = {q_nxt[QUOT_W-2:0], 1'b0};
			if (r_nxt >= {1'b0, d_q}) begin
				r_nxt = r_nxt - {1'b0, d_q};
				q_nxt[0] = 1'b1;
			end
		end
	end

	// Dividend and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {dividend_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			d_q   <= divisor_mag;
		end else if (step) begin
			q_q   <= q_nxt;
			rem_q <= r_nxt[DATA_W-1:0];
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	assign more = (cnt_q != DIV_CNT_W'(DIV_STEPS - 1));
	assign quot = q_q;

endmodule

`default_nettype wire

// File: src/rsc_useq.sv
`default_nettype none

module rsc_useq
	import rsc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire logic      out_busy,
	input  wire dp_flags_t flags,
	output uword_t         uw
);

	logic [UPC_W-1:0] pc_q;
	logic             take;

	assign uw = ucode_rom(pc_q);

	// Jump condition select.
	always_comb begin
		case (uw.cond)
			C_NEVER:   take = 1'b0;
			C_ALWAYS:  take = 1'b1;
			C_NOFIRE:  take = !fire;
			C_KIND:    take = flags.kind;
			C_FULL:    take = flags.full;
			C_FEW:     take = flags.few;
			C_DIV:     take = flags.is_div;
			C_MUL:     take = flags.is_mul;
			C_BZERO:   take = flags.b_zero;
			C_DIVMORE: take = flags.div_more;
			C_OUTBUSY: take = out_busy;
			default:   take = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + UPC_W'(1);
		end
	end

endmodule

`default_nettype wire

// File: src/rsc_dp.sv
`default_nettype none

module rsc_dp
	import rsc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic                kind,
	input  wire logic [DATA_W-1:0]   value,
	input  wire logic [OP_W-1:0]     op,
	input  wire uword_t              uw,
	output dp_flags_t                flags,
	output logic      [STATUS_W-1:0] status,
	output logic      [DATA_W-1:0]   top_value,
	output logic      [DEPTH_W-1:0]  depth,
	output logic      [OPS_W-1:0]    ops_done
);

	logic                      kind_q;
	logic [DATA_W-1:0]         val_q;
	logic [OP_W-1:0]           op_q;
	logic signed [DATA_W-1:0]  a_q;
	logic signed [DATA_W-1:0]  b_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic signed [WIDE_W-1:0]  wide_q;
	logic [DATA_W-1:0]         top_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic [OPS_W-1:0]          ops_q;
	logic [STATUS_W-1:0]       st_q;

	logic [DEPTH_W-1:0]  dm1;
	logic [DEPTH_W-1:0]  dm2;
	logic [ADDR_W-1:0]   raddr;
	logic [ADDR_W-1:0]   waddr;
	logic [DATA_W-1:0]   wdata;
	logic [DATA_W-1:0]   rdata;
	logic                we;
	logic [DATA_W-1:0]   a_mag;
	logic [DATA_W-1:0]   b_mag;
	logic [QUOT_W-1:0]   quot;
	logic                div_more;
	logic signed [WIDE_W-1:0] a_wide;
	logic signed [WIDE_W-1:0] b_wide;
	logic signed [WIDE_W-1:0] q_wide;
	logic                fits;
	logic                sat;
	logic [DATA_W-1:0]   clamp_r;

	// Stack addresses: reads below the current depth, pushes at it.
	assign dm1   = depth_q - DEPTH_W'(1);
	assign dm2   = depth_q - DEPTH_W'(2);
	assign raddr = uw.rd_sec ? dm2[ADDR_W-1:0] : dm1[ADDR_W-1:0];
	assign waddr = uw.push ? depth_q[ADDR_W-1:0] : dm2[ADDR_W-1:0];
	assign wdata = uw.push ? val_q : clamp_r;
	assign we    = uw.push | uw.commit;

	rsc_stack u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Operand magnitudes for the divider.
	assign a_mag = a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
	assign b_mag = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;

	rsc_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (uw.div_start),
		.step         (uw.div_step),
		.dividend_mag (a_mag),
		.divisor_mag  (b_mag),
		.quot         (quot),
		.more         (div_more)
	);

	assign a_wide = WIDE_W'(a_q);
	assign b_wide = WIDE_W'(b_q);
	assign q_wide = (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ?
		-$signed({2'b00, quot}) : $signed({2'b00, quot});

	// Saturation to the 32-bit range.
	assign fits = (&wide_q[WIDE_W-1:DATA_W-1]) | ~(|wide_q[WIDE_W-1:DATA_W-1]);
	assign sat  = !fits;
	always_comb begin
		if (fits) begin
			clamp_r = wide_q[DATA_W-1:0];
		end else if (wide_q[WIDE_W-1]) begin
			clamp_r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			clamp_r = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// Item capture and operand registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= kind;
			val_q  <= value;
			op_q   <= op;
		end
		if (uw.ld_b) begin
			b_q <= rdata;
		end
		if (uw.ld_a) begin
			a_q <= rdata;
		end
		if (uw.mul_go) begin
			prod_q <= a_q * b_q;
		end
	end

	// Wide result register.
	always_ff @(posedge clk) begin
		case (uw.wide_sel)
			W_ADDSUB: wide_q <= (op_q == OP_SUB) ? (a_wide - b_wide) : (a_wide + b_wide);
			W_MUL:    wide_q <= WIDE_W'(prod_q >>> FRAC_W);
			W_DIV:    wide_q <= q_wide;
			default:  wide_q <= wide_q;
		endcase
	end

	// Top of stack and status, updated by pushes, commits and errors.
	always_ff @(posedge clk) begin
		if (uw.push) begin
			top_q <= val_q;
			st_q  <= ST_OK;
		end else if (uw.commit) begin
			top_q <= clamp_r;
			st_q  <= sat ? ST_SAT : ST_OK;
		end else if (uw.st_set) begin
			st_q <= uw.st_code;
		end
	end

	// Depth and completed-operation count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			ops_q   <= '0;
		end else if (uw.push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end else if (uw.commit) begin
			depth_q <= dm1;
			ops_q   <= ops_q + OPS_W'(1);
		end
	end

	assign flags.kind     = (kind_q == KIND_OPER);
	assign flags.full     = (depth_q >= DEPTH_W'(STACK_DEPTH));
	assign flags.few      = (depth_q < DEPTH_W'(2));
	assign flags.is_div   = (op_q == OP_DIV);
	assign flags.is_mul   = (op_q == OP_MUL);
	assign flags.b_zero   = (b_q == '0);
	assign flags.div_more = div_more;

	assign status    = st_q;
	assign top_value = (depth_q == '0) ? '0 : top_q;
	assign depth     = depth_q;
	assign ops_done  = ops_q;

endmodule

`default_nettype wire
